// File: rtl/oul_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oul_pkg: shared types and constants of the ordered unique list engine
// Opcodes, status codes, transfer payloads and the control word that is
// broadcast to every cell of the chain.
// ----------------------------------------------------------------------------
package oul_pkg;

  // default sizes
  localparam int DEPTH_DEF     = 64;
  localparam int KEY_WIDTH_DEF = 32;

  // fixed field widths of the transfers
  localparam int KEY_IN_W  = 32;
  localparam int POS_W     = 7;
  localparam int FPOS_W    = 6;
  localparam int CNT_OUT_W = 7;

  // width of positions and counts inside the cell control word (covers 1024)
  localparam int CTL_W = 11;

  typedef enum logic [3:0] {
    OP_READ      = 4'd0,
    OP_FIND      = 4'd1,
    OP_ADD       = 4'd2,
    OP_ADD_NEW   = 4'd3,
    OP_INSERT    = 4'd4,
    OP_MOVE      = 4'd5,
    OP_REMOVE    = 4'd6,
    OP_REMOVE_IF = 4'd7,
    OP_REMOVE_AT = 4'd8,
    OP_CLEAR     = 4'd9
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // where a cell takes its next key from, inside the shift window
  typedef enum logic [1:0] {
    SH_NONE,
    SH_FROM_LEFT,
    SH_FROM_RIGHT
  } shift_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_APPLY
  } state_e;

  typedef struct packed {
    logic [3:0]          opcode;
    logic [KEY_IN_W-1:0] key;
    logic [POS_W-1:0]    position;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 present;
    logic [FPOS_W-1:0]    found_position;
    logic [KEY_IN_W-1:0]  read_key;
    logic [CNT_OUT_W-1:0] entry_count;
  } rsp_t;

  // broadcast to all cells
  typedef struct packed {
    logic             cmp_en;   // register key compare results
    shift_e           shift;    // shift direction inside [lo, hi]
    logic [CTL_W-1:0] lo;
    logic [CTL_W-1:0] hi;
    logic             load_en;  // load the operand key at load_at
    logic [CTL_W-1:0] load_at;
    logic [CTL_W-1:0] cnt;      // current entry count
    logic [CTL_W-1:0] rd_pos;   // position selected for read-out
  } cell_ctl_t;

endpackage

// File: rtl/oul_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oul_cell: one list slot
// Holds one key, compares it with the operand key, and loads the operand or
// a neighbor's key as the broadcast control word says.
// ----------------------------------------------------------------------------
module oul_cell
  import oul_pkg::*;
#(
  parameter int IDX = 0,
  parameter int KW  = 32
) (
  input  logic          clk,
  input  cell_ctl_t     ctl,
  input  logic [KW-1:0] op_key,
  input  logic [KW-1:0] left_key,
  input  logic [KW-1:0] right_key,
  output logic [KW-1:0] entry,
  output logic          hit,
  output logic [KW-1:0] rd_key
);

  localparam logic [CTL_W-1:0] MY_IDX = CTL_W'(IDX);

  logic in_window;

  assign in_window = (MY_IDX >= ctl.lo) && (MY_IDX <= ctl.hi);

  // key storage: a load wins over a shift
  always_ff @(posedge clk) begin
    if (ctl.load_en && (MY_IDX == ctl.load_at)) begin
      entry <= op_key;
    end else if (in_window && (ctl.shift == SH_FROM_LEFT)) begin
      entry <= left_key;
    end else if (in_window && (ctl.shift == SH_FROM_RIGHT)) begin
      entry <= right_key;
    end
  end

  // compare result, only for occupied slots
  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      hit <= (MY_IDX < ctl.cnt) && (entry == op_key);
    end
  end

  // read-out contribution, zero unless selected
  assign rd_key = (MY_IDX == ctl.rd_pos) ? entry : '0;

endmodule

// File: rtl/oul_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oul_reduce: collects the cell outputs
// Keys are unique, so at most one cell hits: the position is an OR of the
// hitting indexes. The read-out is an OR of the cells' gated keys.
// ----------------------------------------------------------------------------
module oul_reduce
  import oul_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int KW    = 32,
  parameter int IW    = $clog2(DEPTH)
) (
  input  logic [DEPTH-1:0] hits,
  input  logic [KW-1:0]    rd_keys [DEPTH],
  output logic             has,
  output logic [IW-1:0]    where,
  output logic [KW-1:0]    rd_data
);

  // one-hot to index, and read-out OR
  always_comb begin
    where   = '0;
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      where   = where | (hits[i] ? IW'(i) : '0);
      rd_data = rd_data | rd_keys[i];
    end
  end

  assign has = |hits;

endmodule

// File: rtl/ordered_unique_list_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_unique_list_engine_core: ordered list of unique keys
// A chain of DEPTH cells holds the keys in list order. Lookups compare all
// cells at once; insert, move and remove shift a window of cells by one.
//
//   channel | valid     | stall     | payload | moves
//   --------+-----------+-----------+---------+------------------------------
//   request | req_valid | req_stall | req     | opcode, key, position
//   result  | rsp_valid | rsp_stall | rsp     | status, present, position,
//           |           |           |         | read key, entry count
//
// Each request passes the LOOKUP and APPLY states: LOOKUP registers the compare
// in every cell, APPLY encodes the hit and shifts the chain while the result is registered.
// A new request is taken in APPLY, so the block takes no request before the last is through.
// A stalled result holds the block in APPLY until it is taken.
// Reset clears the count and the FSM; key storage is not cleared.
// ----------------------------------------------------------------------------
module ordered_unique_list_engine_core
  import oul_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int KW   = (KEY_WIDTH < KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;
  localparam int IW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam logic [CTL_W-1:0] DEPTH_C = CTL_W'(DEPTH);

  state_e           state, state_next;
  logic [CNTW-1:0]  count;
  logic [3:0]       cmd_op;
  logic [KW-1:0]    cmd_key;
  logic [POS_W-1:0] cmd_pos;

  cell_ctl_t        ctl;
  logic [KW-1:0]    cell_key [DEPTH];
  logic [KW-1:0]    cell_rd  [DEPTH];
  logic [DEPTH-1:0] cell_hit;

  logic             has;
  logic [IW-1:0]    where;
  logic [KW-1:0]    rd_data;

  logic             out_free;
  logic             applying;
  logic             accept;
  logic             lookup_op;

  // evaluation of the current command
  status_e          res_status;
  logic [KW-1:0]    res_rkey;
  logic [CTL_W-1:0] cnt_new;
  shift_e           ap_shift;
  logic [CTL_W-1:0] ap_lo;
  logic [CTL_W-1:0] ap_hi;
  logic             ap_load;
  logic [CTL_W-1:0] ap_at;
  logic [CTL_W-1:0] pos_w;
  logic [CTL_W-1:0] cnt_w;
  logic [CTL_W-1:0] where_w;
  rsp_t             rsp_next;

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KW-1:0] left_in;
    logic [KW-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = cmd_key;
    end else begin : g_mid
      assign left_in = cell_key[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_in = cell_key[i];
    end else begin : g_inner
      assign right_in = cell_key[i+1];
    end
    oul_cell #(
      .IDX (i),
      .KW  (KW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .op_key    (cmd_key),
      .left_key  (left_in),
      .right_key (right_in),
      .entry     (cell_key[i]),
      .hit       (cell_hit[i]),
      .rd_key    (cell_rd[i])
    );
  end

  oul_reduce #(
    .DEPTH (DEPTH),
    .KW    (KW),
    .IW    (IW)
  ) u_reduce (
    .hits    (cell_hit),
    .rd_keys (cell_rd),
    .has     (has),
    .where   (where),
    .rd_data (rd_data)
  );

  assign out_free = !rsp_valid || !rsp_stall;
  assign applying = (state == S_APPLY) && out_free;
  assign accept   = req_valid && !req_stall;
  assign pos_w    = CTL_W'(cmd_pos);
  assign cnt_w    = CTL_W'(count);
  assign where_w  = CTL_W'(where);
  assign lookup_op = (cmd_op >= 4'(OP_FIND)) && (cmd_op <= 4'(OP_REMOVE_IF));

  // operation decode: status, new count and chain update
  always_comb begin
    res_status = ST_OK;
    res_rkey   = '0;
    cnt_new    = cnt_w;
    ap_shift   = SH_NONE;
    ap_lo      = '0;
    ap_hi      = '1;
    ap_load    = 1'b0;
    ap_at      = '0;
    case (opcode_e'(cmd_op))
      OP_READ: begin
        if (pos_w < cnt_w) begin
          res_rkey = rd_data;
        end else begin
          res_status = ST_BAD;
        end
      end
      OP_FIND: begin
        if (!has) begin
          res_status = ST_BAD;
        end
      end
      OP_ADD, OP_ADD_NEW: begin
        if (has) begin
          res_status = (opcode_e'(cmd_op) == OP_ADD) ? ST_BAD : ST_OK;
        end else if (cnt_w >= DEPTH_C) begin
          res_status = ST_FULL;
        end else begin
          ap_load = 1'b1;
          ap_at   = cnt_w;
          cnt_new = cnt_w + 1'b1;
        end
      end
      OP_INSERT: begin
        if (has || (pos_w > cnt_w)) begin
          res_status = ST_BAD;
        end else if (cnt_w >= DEPTH_C) begin
          res_status = ST_FULL;
        end else begin
          ap_shift = SH_FROM_LEFT;
          ap_lo    = pos_w + 1'b1;
          ap_load  = 1'b1;
          ap_at    = pos_w;
          cnt_new  = cnt_w + 1'b1;
        end
      end
      OP_MOVE: begin
        if (!has || (pos_w >= cnt_w)) begin
          res_status = ST_BAD;
        end else begin
          ap_load = 1'b1;
          ap_at   = pos_w;
          if (pos_w < where_w) begin
            ap_shift = SH_FROM_LEFT;
            ap_lo    = pos_w + 1'b1;
            ap_hi    = where_w;
          end else if (pos_w > where_w) begin
            ap_shift = SH_FROM_RIGHT;
            ap_lo    = where_w;
            ap_hi    = pos_w - 1'b1;
          end
        end
      end
      OP_REMOVE, OP_REMOVE_IF: begin
        if (has) begin
          ap_shift = SH_FROM_RIGHT;
          ap_lo    = where_w;
          cnt_new  = cnt_w - 1'b1;
        end else if (opcode_e'(cmd_op) == OP_REMOVE) begin
          res_status = ST_BAD;
        end
      end
      OP_REMOVE_AT: begin
        if (pos_w < cnt_w) begin
          ap_shift = SH_FROM_RIGHT;
          ap_lo    = pos_w;
          cnt_new  = cnt_w - 1'b1;
        end else begin
          res_status = ST_BAD;
        end
      end
      OP_CLEAR: begin
        cnt_new = '0;
      end
      default: begin
        res_status = ST_BAD;
      end
    endcase
  end

  // result word
  always_comb begin
    rsp_next.status         = res_status;
    rsp_next.present        = lookup_op && has;
    rsp_next.found_position = (lookup_op && has) ? where_w[FPOS_W-1:0] : '0;
    rsp_next.read_key       = KEY_IN_W'(res_rkey);
    rsp_next.entry_count    = cnt_new[CNT_OUT_W-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) begin
          state_next = req_valid ? S_LOOKUP : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // FSM outputs: request stall and cell control word
  always_comb begin
    req_stall   = !((state == S_IDLE) || applying);
    ctl.cmp_en  = (state == S_LOOKUP);
    ctl.shift   = applying ? ap_shift : SH_NONE;
    ctl.lo      = ap_lo;
    ctl.hi      = ap_hi;
    ctl.load_en = applying && ap_load;
    ctl.load_at = ap_at;
    ctl.cnt     = cnt_w;
    ctl.rd_pos  = pos_w;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (applying) begin
        count     <= cnt_new[CNTW-1:0];
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // command and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_op  <= req.opcode;
      cmd_key <= req.key[KW-1:0];
      cmd_pos <= req.position;
    end
    if (applying) begin
      rsp <= rsp_next;
    end
  end

endmodule

// File: rtl/oul_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oul_checker: port-level checks of the list engine
// Watches both transfers and the reset behavior of the result channel.
// ----------------------------------------------------------------------------
module oul_checker
  import oul_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // a waiting result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // a request is never followed by another in the next cycle
  a_req_spacing: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("requests accepted in back-to-back cycles");

  // no result right after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

  // position only reported for a present key
  a_pos_present: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.present |-> rsp.found_position == '0)
    else $error("position without present key");

  // status code is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status != 2'd3)
    else $error("undefined status code");

endmodule

bind ordered_unique_list_engine_core oul_checker u_oul_checker (.*);
